// File: design/llfp_pkg.sv
package llfp_pkg;

   // Default node pool size
   localparam int unsigned DefPoolNodes = 256;
   // Fixed field widths
   localparam int unsigned OpWidth     = 2;
   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned StatusWidth = 3;
   localparam int unsigned CountWidth  = 9;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_AT_TAIL   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_WALK,
      S_TAKE,
      S_APP_LINK,
      S_INS_LINK,
      S_DEL_UNLINK,
      S_DEL_FREE,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       idle;
      logic       report;
      logic       clear_step;
      logic       latch_req;
      logic       walk_start;
      logic       walk_next;
      logic       save_nxt;
      logic       nil_nxt;
      logic       take_rd;
      logic       take;
      logic       app_link;
      logic       ins_link;
      logic       del_unlink;
      logic       del_free;
      logic       set_status;
      status_type status;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic   clear_last;
      logic   head_nil;
      logic   free_nil;
      logic   match;
      logic   link_nil;
      op_type op;
   } dp_stat_type;

endpackage

// File: design/llfp_ctrl.sv
module llfp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  llfp_pkg::dp_stat_type  stat,
   output llfp_pkg::ctrl_cmd_type cmd,
   output logic                   busy
);

   llfp_pkg::state_type state_ff;
   llfp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= llfp_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         llfp_pkg::S_CLEAR: begin
            if (stat.clear_last) state_in = llfp_pkg::S_IDLE;
         end
         llfp_pkg::S_IDLE: begin
            if (start) state_in = llfp_pkg::S_DISPATCH;
         end
         llfp_pkg::S_DISPATCH: begin
            case (stat.op)
               llfp_pkg::OP_APPEND: begin
                  state_in = stat.free_nil ? llfp_pkg::S_DONE : llfp_pkg::S_TAKE;
               end
               llfp_pkg::OP_INSERT, llfp_pkg::OP_DELETE: begin
                  state_in = stat.head_nil ? llfp_pkg::S_DONE : llfp_pkg::S_WALK;
               end
               default: state_in = llfp_pkg::S_DONE;
            endcase
         end
         llfp_pkg::S_WALK: begin
            if (stat.match) begin
               if (stat.op == llfp_pkg::OP_DELETE) begin
                  state_in = llfp_pkg::S_DEL_UNLINK;
               end else if (stat.link_nil || stat.free_nil) begin
                  state_in = llfp_pkg::S_DONE;
               end else begin
                  state_in = llfp_pkg::S_TAKE;
               end
            end else if (stat.link_nil) begin
               state_in = llfp_pkg::S_DONE;
            end
         end
         llfp_pkg::S_TAKE: begin
            state_in = (stat.op == llfp_pkg::OP_APPEND) ? llfp_pkg::S_APP_LINK
                                                        : llfp_pkg::S_INS_LINK;
         end
         llfp_pkg::S_APP_LINK:   state_in = llfp_pkg::S_DONE;
         llfp_pkg::S_INS_LINK:   state_in = llfp_pkg::S_DONE;
         llfp_pkg::S_DEL_UNLINK: state_in = llfp_pkg::S_DEL_FREE;
         llfp_pkg::S_DEL_FREE:   state_in = llfp_pkg::S_DONE;
         llfp_pkg::S_DONE:       state_in = llfp_pkg::S_IDLE;
         default:                state_in = llfp_pkg::S_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      cmd.status = llfp_pkg::ST_OK;
      case (state_ff)
         llfp_pkg::S_CLEAR: cmd.clear_step = 1'b1;
         llfp_pkg::S_IDLE: begin
            cmd.idle      = 1'b1;
            cmd.latch_req = start;
         end
         llfp_pkg::S_DISPATCH: begin
            cmd.set_status = 1'b1;
            case (stat.op)
               llfp_pkg::OP_APPEND: begin
                  if (stat.free_nil) begin
                     cmd.status = llfp_pkg::ST_FULL;
                  end else begin
                     cmd.take_rd = 1'b1;
                     cmd.nil_nxt = 1'b1;
                  end
               end
               llfp_pkg::OP_INSERT, llfp_pkg::OP_DELETE: begin
                  if (stat.head_nil) begin
                     cmd.status = llfp_pkg::ST_EMPTY;
                  end else begin
                     cmd.walk_start = 1'b1;
                  end
               end
               default: cmd.status = llfp_pkg::ST_OK;
            endcase
         end
         llfp_pkg::S_WALK: begin
            if (stat.match) begin
               cmd.set_status = 1'b1;
               if (stat.op == llfp_pkg::OP_DELETE) begin
                  cmd.save_nxt = 1'b1;
               end else if (stat.link_nil) begin
                  cmd.status = llfp_pkg::ST_AT_TAIL;
               end else if (stat.free_nil) begin
                  cmd.status = llfp_pkg::ST_FULL;
               end else begin
                  cmd.save_nxt = 1'b1;
                  cmd.take_rd  = 1'b1;
               end
            end else if (stat.link_nil) begin
               cmd.set_status = 1'b1;
               cmd.status     = llfp_pkg::ST_NOT_FOUND;
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         llfp_pkg::S_TAKE:       cmd.take       = 1'b1;
         llfp_pkg::S_APP_LINK:   cmd.app_link   = 1'b1;
         llfp_pkg::S_INS_LINK:   cmd.ins_link   = 1'b1;
         llfp_pkg::S_DEL_UNLINK: cmd.del_unlink = 1'b1;
         llfp_pkg::S_DEL_FREE:   cmd.del_free   = 1'b1;
         llfp_pkg::S_DONE:       cmd.report     = 1'b1;
         default:                cmd.idle       = 1'b0;
      endcase
   end

   assign busy = (state_ff != llfp_pkg::S_IDLE);

endmodule

// File: design/llfp_dpath.sv
module llfp_dpath #(
   parameter int unsigned POOL_NODES = llfp_pkg::DefPoolNodes
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  llfp_pkg::ctrl_cmd_type                      cmd,
   input  logic [llfp_pkg::OpWidth-1:0]                req_operation,
   input  logic signed [llfp_pkg::ValueWidth-1:0]      req_item_value,
   input  logic signed [llfp_pkg::ValueWidth-1:0]      req_search_key,
   output llfp_pkg::dp_stat_type                       stat,
   output logic [llfp_pkg::StatusWidth-1:0]            status,
   output logic [llfp_pkg::CountWidth-1:0]             free_count,
   output logic [llfp_pkg::CountWidth-1:0]             list_count
);

   localparam int unsigned AW   = $clog2(POOL_NODES);
   localparam int unsigned LW   = $clog2(POOL_NODES + 1);
   localparam int unsigned CW   = $clog2(POOL_NODES + 1);
   localparam int unsigned VW   = llfp_pkg::ValueWidth;
   localparam int unsigned CntW = llfp_pkg::CountWidth;
   localparam logic [LW-1:0] Nil  = LW'(POOL_NODES);
   localparam logic [AW-1:0] Last = AW'(POOL_NODES - 1);

   function automatic logic is_node(input logic [LW-1:0] p);
      return p < Nil;
   endfunction

   // Node store
   logic [VW-1:0] val_mem  [POOL_NODES];
   logic [LW-1:0] link_mem [POOL_NODES];

   logic [VW-1:0] rd_val_ff;
   logic [LW-1:0] rd_link_ff;

   llfp_pkg::op_type     op_ff,  op_in;
   logic [VW-1:0]        value_ff, value_in;
   logic [VW-1:0]        key_ff, key_in;
   logic [LW-1:0]        head_ff, head_in;
   logic [LW-1:0]        tail_ff, tail_in;
   logic [LW-1:0]        free_head_ff, free_head_in;
   logic [CW-1:0]        free_total_ff, free_total_in;
   logic [CW-1:0]        list_total_ff, list_total_in;
   logic [LW-1:0]        cur_ff, cur_in;
   logic [LW-1:0]        prev_ff, prev_in;
   logic [LW-1:0]        nxt_ff, nxt_in;
   logic [LW-1:0]        node_ff, node_in;
   llfp_pkg::status_type status_ff, status_in;
   logic [AW-1:0]        clr_idx_ff, clr_idx_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          vw_en;
   logic [AW-1:0] vw_addr;
   logic [VW-1:0] vw_data;
   logic          lw_en;
   logic [AW-1:0] lw_addr;
   logic [LW-1:0] lw_data;
   logic [VW-1:0] target;

   // Memory port selection
   always_comb begin
      rd_en   = cmd.walk_start | cmd.walk_next | cmd.take_rd;
      if (cmd.take_rd) begin
         rd_addr = free_head_ff[AW-1:0];
      end else if (cmd.walk_next) begin
         rd_addr = rd_link_ff[AW-1:0];
      end else begin
         rd_addr = head_ff[AW-1:0];
      end

      vw_en   = 1'b0;
      vw_addr = cur_ff[AW-1:0];
      vw_data = '0;
      if (cmd.clear_step) begin
         vw_en   = 1'b1;
         vw_addr = clr_idx_ff;
      end else if (cmd.take) begin
         vw_en   = 1'b1;
         vw_addr = free_head_ff[AW-1:0];
         vw_data = value_ff;
      end else if (cmd.del_unlink) begin
         vw_en   = 1'b1;
      end

      lw_en   = 1'b0;
      lw_addr = cur_ff[AW-1:0];
      lw_data = node_ff;
      if (cmd.clear_step) begin
         lw_en   = 1'b1;
         lw_addr = clr_idx_ff;
         lw_data = LW'(clr_idx_ff) + LW'(1);
      end else if (cmd.take) begin
         lw_en   = 1'b1;
         lw_addr = free_head_ff[AW-1:0];
         lw_data = nxt_ff;
      end else if (cmd.app_link) begin
         lw_en   = is_node(tail_ff);
         lw_addr = tail_ff[AW-1:0];
      end else if (cmd.ins_link) begin
         lw_en   = 1'b1;
      end else if (cmd.del_unlink) begin
         lw_en   = is_node(prev_ff);
         lw_addr = prev_ff[AW-1:0];
         lw_data = nxt_ff;
      end else if (cmd.del_free) begin
         lw_en   = 1'b1;
         lw_data = free_head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (vw_en) val_mem[vw_addr] <= vw_data;
      if (lw_en) link_mem[lw_addr] <= lw_data;
      if (rd_en) begin
         rd_val_ff  <= val_mem[rd_addr];
         rd_link_ff <= link_mem[rd_addr];
      end
   end

   // Register updates
   always_comb begin
      op_in         = op_ff;
      value_in      = value_ff;
      key_in        = key_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_head_in  = free_head_ff;
      free_total_in = free_total_ff;
      list_total_in = list_total_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      nxt_in        = nxt_ff;
      node_in       = node_ff;
      status_in     = status_ff;
      clr_idx_in    = clr_idx_ff;

      if (cmd.clear_step) clr_idx_in = (clr_idx_ff == Last) ? '0 : clr_idx_ff + AW'(1);
      if (cmd.latch_req) begin
         op_in    = llfp_pkg::op_type'(req_operation);
         value_in = req_item_value;
         key_in   = req_search_key;
      end
      if (cmd.walk_start) begin
         cur_in  = head_ff;
         prev_in = Nil;
      end
      if (cmd.walk_next) begin
         prev_in = cur_ff;
         cur_in  = rd_link_ff;
      end
      if (cmd.save_nxt) nxt_in = rd_link_ff;
      if (cmd.nil_nxt)  nxt_in = Nil;
      if (cmd.take) begin
         node_in       = free_head_ff;
         free_head_in  = rd_link_ff;
         free_total_in = free_total_ff - CW'(1);
      end
      if (cmd.app_link) begin
         if (!is_node(tail_ff)) head_in = node_ff;
         tail_in       = node_ff;
         list_total_in = list_total_ff + CW'(1);
      end
      if (cmd.ins_link) list_total_in = list_total_ff + CW'(1);
      if (cmd.del_unlink) begin
         if (!is_node(prev_ff)) head_in = nxt_ff;
         if (tail_ff == cur_ff) tail_in = prev_ff;
      end
      if (cmd.del_free) begin
         free_head_in  = cur_ff;
         free_total_in = free_total_ff + CW'(1);
         list_total_in = list_total_ff - CW'(1);
      end
      if (cmd.set_status) status_in = cmd.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= Nil;
         tail_ff       <= Nil;
         free_head_ff  <= '0;
         free_total_ff <= CW'(POOL_NODES);
         list_total_ff <= '0;
         clr_idx_ff    <= '0;
         status_ff     <= llfp_pkg::ST_OK;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_head_ff  <= free_head_in;
         free_total_ff <= free_total_in;
         list_total_ff <= list_total_in;
         clr_idx_ff    <= clr_idx_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      key_ff   <= key_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      nxt_ff   <= nxt_in;
      node_ff  <= node_in;
   end

   assign target = (op_ff == llfp_pkg::OP_INSERT) ? key_ff : value_ff;

   always_comb begin
      stat.clear_last = (clr_idx_ff == Last);
      stat.head_nil   = !is_node(head_ff);
      stat.free_nil   = !is_node(free_head_ff);
      stat.match      = (rd_val_ff == target);
      stat.link_nil   = !is_node(rd_link_ff);
      stat.op         = op_ff;
   end

   assign status     = status_ff;
   assign free_count = CntW'(free_total_ff);
   assign list_count = CntW'(list_total_ff);

   // The free and list node counts add up to the pool size when a result goes out
   a_pool_conserved: assert property (@(posedge clock) disable iff (reset)
      cmd.report |-> ((CW+1)'(free_total_ff) + (CW+1)'(list_total_ff)
                      == (CW+1)'(POOL_NODES)))
      else $error("node counts do not add up to the pool size");

   a_head_vs_count: assert property (@(posedge clock) disable iff (reset)
      cmd.idle |-> (is_node(head_ff) == (list_total_ff != '0)))
      else $error("list head disagrees with list count");

   a_tail_vs_count: assert property (@(posedge clock) disable iff (reset)
      cmd.idle |-> (is_node(tail_ff) == (list_total_ff != '0)))
      else $error("list tail disagrees with list count");

   a_free_vs_count: assert property (@(posedge clock) disable iff (reset)
      cmd.idle |-> (is_node(free_head_ff) == (free_total_ff != '0)))
      else $error("free head disagrees with free count");

endmodule

// File: design/linked_list_with_free_pool.sv
// Channel   Ports                                              Handshake
// -------   -------------------------------------------------  --------------------------------
// request   req_operation, req_item_value, req_search_key      taken when start && !busy
// response  rsp_status, rsp_free_count, rsp_list_count         one cycle, marked by rsp_valid
//
// Steps: append runs dispatch, take, link and the report of the result, then is idle again.
// Insert walks to the matching node, then takes and links; delete walks, unlinks and frees; a
// miss reports once the walk reaches the list tail. Each request ends before the next is taken.
// The walk is bound by the single read port of the node store: one node per cycle.
// Reset: a clearing pass over all POOL_NODES nodes rebuilds the free chain; busy stays high.
// The receiver cannot stall: each result is shown once and the block then returns to idle.
module linked_list_with_free_pool #(
   parameter int unsigned POOL_NODES = llfp_pkg::DefPoolNodes
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [llfp_pkg::OpWidth-1:0]           req_operation,
   input  logic signed [llfp_pkg::ValueWidth-1:0] req_item_value,
   input  logic signed [llfp_pkg::ValueWidth-1:0] req_search_key,
   output logic                                   rsp_valid,
   output logic [llfp_pkg::StatusWidth-1:0]       rsp_status,
   output logic [llfp_pkg::CountWidth-1:0]        rsp_free_count,
   output logic [llfp_pkg::CountWidth-1:0]        rsp_list_count
);

   // Controller drives commands, datapath reports list conditions back
   llfp_pkg::ctrl_cmd_type cmd;
   llfp_pkg::dp_stat_type  stat;

   // Sequence the request: dispatch, walk, take or free a node, relink, report
   llfp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Hold node store, list pointers and counts
   llfp_dpath #(
      .POOL_NODES (POOL_NODES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_operation),
      .req_item_value (req_item_value),
      .req_search_key (req_search_key),
      .stat           (stat),
      .status         (rsp_status),
      .free_count     (rsp_free_count),
      .list_count     (rsp_list_count)
   );

   // Strobe the result for its single report cycle
   assign rsp_valid = cmd.report;

endmodule
